>>> hw/rtl/moller_expected_energy_unit_assert.svh
// Assertion macros for the Moller expected energy unit.
// Included by the top level; no other dependencies.
`ifndef MOLLER_EXPECTED_ENERGY_UNIT_ASSERT_SVH
`define MOLLER_EXPECTED_ENERGY_UNIT_ASSERT_SVH

// ante must be followed by cons (cons may carry its own delay)
`define MEE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error(msg);

// expr must never hold outside reset
`define MEE_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);

`endif

>>> hw/rtl/mee_pkg.sv
// Shared constants and helpers for the Moller expected energy unit.
// No dependencies.
`timescale 1ns / 1ps

package mee_pkg;

   localparam int ANGLE_WIDTH    = 24;
   localparam int ENERGY_WIDTH   = 35;
   localparam int QUOT_WIDTH     = 35;
   localparam int HORNER_TERMS   = 9;
   localparam int HORNER_LATENCY = 3;
   // fold, square, Horner steps, final square
   localparam int COS_LATENCY    = 3 + HORNER_TERMS * HORNER_LATENCY;
   localparam int ENERGY_LATENCY = 4;
   localparam int PIPE_LATENCY   = COS_LATENCY + ENERGY_LATENCY + QUOT_WIDTH;

   localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C234;
   localparam logic [ENERGY_WIDTH-1:0] BEAM_RESET = 35'd2200000000;

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   function automatic int min_int(input int a, input int b);
      return (a < b) ? a : b;
   endfunction

endpackage

>>> hw/rtl/mee_horner.sv
// One Horner step of the cosine series: t <- 1 - floor(floor(t*x2)/(2k(2k-1))).
// Three register stages. Depends on mee_pkg.
`timescale 1ns / 1ps

module mee_horner #(
   parameter int F   = 30,
   parameter int X2W = 34,
   parameter int VW  = 35,
   parameter int K   = 1
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  logic [F:0]     in_t,
   input  logic [X2W-1:0] in_x2,
   output logic           out_valid,
   output logic [F:0]     out_t,
   output logic [X2W-1:0] out_x2
);

   localparam int TW  = F + 1;
   localparam int DK  = 2 * K * (2 * K - 1);
   localparam int DKW = $clog2(DK + 1);
   localparam int SH  = VW + $clog2(DK);
   localparam int RW  = VW + 1;
   localparam logic [127:0] RECIP_WIDE = (128'd1 << SH) / 128'(DK);
   localparam logic [RW-1:0] RECIP = RECIP_WIDE[RW-1:0];
   localparam logic [DKW-1:0] DIVISOR = DKW'(DK);
   localparam int QCW = mee_pkg::max_int(VW, TW) + 1;
   localparam logic [QCW-1:0] ONE = QCW'(1) << F;

   logic           v1_ff, v2_ff, v3_ff;
   logic [VW-1:0]  prod_in, prod_ff, prod2_ff;
   logic [VW-1:0]  est_in, est_ff;
   logic [X2W-1:0] x2a_ff, x2b_ff, x2c_ff;
   logic [TW-1:0]  t_in, t_ff;

   logic [TW+X2W-1:0] mul1;
   logic [VW+RW-1:0]  mul2;
   logic [VW+DKW-1:0] chk;
   logic [VW-1:0]     rem;
   logic [QCW-1:0]    quot;

   always_comb begin
      mul1    = (TW + X2W)'(in_t) * (TW + X2W)'(in_x2);
      prod_in = VW'(mul1 >> F);
      mul2    = (VW + RW)'(prod_ff) * (VW + RW)'(RECIP);
      est_in  = VW'(mul2 >> SH);
      // estimate is exact or one low
      chk     = (VW + DKW)'(est_ff) * (VW + DKW)'(DIVISOR);
      rem     = prod2_ff - VW'(chk);
      quot    = QCW'(est_ff) + ((rem >= VW'(DIVISOR)) ? QCW'(1) : QCW'(0));
      t_in    = (quot >= ONE) ? '0 : TW'(ONE - quot);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      prod_ff  <= prod_in;
      x2a_ff   <= in_x2;
      est_ff   <= est_in;
      prod2_ff <= prod_ff;
      x2b_ff   <= x2a_ff;
      t_ff     <= t_in;
      x2c_ff   <= x2b_ff;
   end

   assign out_valid = v3_ff;
   assign out_t     = t_ff;
   assign out_x2    = x2c_ff;

endmodule

>>> hw/rtl/mee_cos2.sv
// Pipelined cos^2 of the angle in fixed point: fold, square, nine Horner steps, square.
// Depends on mee_pkg and mee_horner.
`timescale 1ns / 1ps

module mee_cos2 #(
   parameter int ANGLE_FRAC_BITS  = 22,
   parameter int COSINE_FRAC_BITS = 30
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic [mee_pkg::ANGLE_WIDTH-1:0]  in_theta,
   output logic                             out_valid,
   output logic [COSINE_FRAC_BITS:0]        out_c2
);

   localparam int F   = COSINE_FRAC_BITS;
   localparam int A   = ANGLE_FRAC_BITS;
   localparam int TW  = F + 1;
   localparam int XW0 = mee_pkg::ANGLE_WIDTH + F - A;
   localparam int XW  = mee_pkg::max_int(XW0, F + 2);
   localparam int X2W = mee_pkg::min_int(64, 2 * XW - F);
   localparam int VW  = mee_pkg::min_int(64, X2W + 1);
   localparam int NT  = mee_pkg::HORNER_TERMS;
   localparam logic [63:0] PI_F64 = mee_pkg::PI_Q62 >> (62 - F);
   localparam logic [XW-1:0] PI_F   = XW'(PI_F64);
   localparam logic [XW-1:0] HALF_F = PI_F >> 1;

   logic [XW-1:0] x0, x_in, x_ff;
   logic          fold_v_ff, sq_v_ff, c2_v_ff;
   logic [2*XW-1:0] xsq;
   logic [X2W-1:0]  x2_ff;
   logic [2*TW-1:0] tsq;
   logic [TW-1:0]   c2_ff;

   logic           st_v  [0:NT];
   logic [TW-1:0]  st_t  [0:NT];
   logic [X2W-1:0] st_x2 [0:NT];

   if (F >= A) begin : g_up
      assign x0 = XW'(in_theta) << (F - A);
   end else begin : g_down
      assign x0 = XW'(in_theta >> (A - F));
   end

   // only c^2 is used, so fold about pi/2 without tracking sign
   always_comb begin
      if (x0 > HALF_F) begin
         x_in = (x0 > PI_F) ? (x0 - PI_F) : (PI_F - x0);
      end else begin
         x_in = x0;
      end
      xsq = (2 * XW)'(x_ff) * (2 * XW)'(x_ff);
      tsq = (2 * TW)'(st_t[NT]) * (2 * TW)'(st_t[NT]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_v_ff <= 1'b0;
         sq_v_ff   <= 1'b0;
         c2_v_ff   <= 1'b0;
      end else begin
         fold_v_ff <= in_valid;
         sq_v_ff   <= fold_v_ff;
         c2_v_ff   <= st_v[NT];
      end
      x_ff  <= x_in;
      x2_ff <= X2W'(xsq >> F);
      c2_ff <= TW'(tsq >> F);
   end

   assign st_v[0]  = sq_v_ff;
   assign st_t[0]  = TW'(1) << F;
   assign st_x2[0] = x2_ff;

   for (genvar j = 0; j < NT; j++) begin : g_step
      mee_horner #(
         .F   (F),
         .X2W (X2W),
         .VW  (VW),
         .K   (NT - j)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (st_v[j]),
         .in_t      (st_t[j]),
         .in_x2     (st_x2[j]),
         .out_valid (st_v[j+1]),
         .out_t     (st_t[j+1]),
         .out_x2    (st_x2[j+1])
      );
   end

   assign out_valid = c2_v_ff;
   assign out_c2    = c2_ff;

endmodule

>>> hw/rtl/mee_energy.sv
// Builds dividend 2mN+D and divisor 2D of the energy quotient from cos^2.
// Four register stages. Depends on mee_pkg.
`timescale 1ns / 1ps

module mee_energy #(
   parameter int ELECTRON_MASS_EV = 510999,
   parameter int F                = 30,
   parameter int TOPW             = 89,
   parameter int DW               = 68
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [mee_pkg::ENERGY_WIDTH-1:0]   beam,
   input  logic                               in_valid,
   input  logic [F:0]                         in_c2,
   output logic                               out_valid,
   output logic [TOPW-1:0]                    out_top,
   output logic [DW-1:0]                      out_den2
);

   localparam int EW   = mee_pkg::ENERGY_WIDTH;
   localparam int CW   = F + 1;
   localparam int MW   = $clog2(ELECTRON_MASS_EV + 1);
   localparam int DLO  = 18;
   localparam int DHI  = EW - DLO;
   localparam int DCW  = EW + CW;
   localparam int NW   = EW + 2 + F;
   localparam int NLO  = NW / 2;
   localparam int NHI  = NW - NLO;
   localparam logic [EW-1:0] MASS = EW'(ELECTRON_MASS_EV);

   // derived from the beam register; they settle long before the cos^2 of any later angle arrives
   logic [EW:0]   sum_ff;
   logic [EW-1:0] dist_ff;
   logic          above_ff;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic [DLO+CW-1:0] plo_ff;
   logic [DHI+CW-1:0] phi_ff;
   logic [NW-1:0]     num_in, num_ff, den_in, den_ff, den2_ff, den3_ff;
   logic [DCW-1:0]    dc;
   logic [NW-1:0]     base;
   logic [NLO+MW-1:0] mlo_ff;
   logic [NHI+MW-1:0] mhi_ff;
   logic [NW+MW-1:0]  mn;
   logic [TOPW-1:0]   top_ff;

   always_comb begin
      dc     = (DCW'(phi_ff) << DLO) + DCW'(plo_ff);
      base   = NW'(sum_ff) << F;
      num_in = above_ff ? (base + NW'(dc)) : (base - NW'(dc));
      den_in = above_ff ? (base - NW'(dc)) : (base + NW'(dc));
      mn     = ((NW + MW)'(mhi_ff) << NLO) + (NW + MW)'(mlo_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      above_ff <= (beam >= MASS);
      dist_ff  <= (beam >= MASS) ? (beam - MASS) : (MASS - beam);
      sum_ff   <= (EW + 1)'(beam) + (EW + 1)'(MASS);
      plo_ff   <= (DLO + CW)'(dist_ff[DLO-1:0]) * (DLO + CW)'(in_c2);
      phi_ff   <= (DHI + CW)'(dist_ff[EW-1:DLO]) * (DHI + CW)'(in_c2);
      num_ff   <= num_in;
      den_ff   <= den_in;
      mlo_ff   <= (NLO + MW)'(num_ff[NLO-1:0]) * (NLO + MW)'(MASS[MW-1:0]);
      mhi_ff   <= (NHI + MW)'(num_ff[NW-1:NLO]) * (NHI + MW)'(MASS[MW-1:0]);
      den2_ff  <= den_ff;
      top_ff   <= (TOPW'(mn) << 1) + TOPW'(den2_ff);
      den3_ff  <= den2_ff;
   end

   assign out_valid = v4_ff;
   assign out_top   = top_ff;
   assign out_den2  = DW'(den3_ff) << 1;

endmodule

>>> hw/rtl/mee_div.sv
// Pipelined restoring divider, one quotient bit per stage, top bit first.
// Depends on mee_pkg.
`timescale 1ns / 1ps

module mee_div #(
   parameter int TOPW = 89,
   parameter int DW   = 68
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic [TOPW-1:0]                  in_top,
   input  logic [DW-1:0]                    in_den2,
   output logic                             out_valid,
   output logic [mee_pkg::QUOT_WIDTH-1:0]   out_quot
);

   localparam int QW   = mee_pkg::QUOT_WIDTH;
   localparam int CMPW = mee_pkg::max_int(TOPW, DW + QW);

   logic            st_v   [0:QW];
   logic [TOPW-1:0] st_rem [0:QW];
   logic [DW-1:0]   st_den [0:QW];
   logic [QW-1:0]   st_q   [0:QW];

   assign st_v[0]   = in_valid;
   assign st_rem[0] = in_top;
   assign st_den[0] = in_den2;
   assign st_q[0]   = '0;

   // quotient is known to fit QW bits, so remainder stays below den2 << (bit+1)
   for (genvar j = 0; j < QW; j++) begin : g_bit
      localparam int B = QW - 1 - j;
      logic [CMPW-1:0] shifted, rem_ext;
      logic            take;
      logic [TOPW-1:0] rem_in;
      logic [QW-1:0]   q_in;
      logic            v_ff;
      logic [TOPW-1:0] rem_ff;
      logic [DW-1:0]   den_ff;
      logic [QW-1:0]   q_ff;

      always_comb begin
         shifted = CMPW'(st_den[j]) << B;
         rem_ext = CMPW'(st_rem[j]);
         take    = (rem_ext >= shifted);
         rem_in  = take ? TOPW'(rem_ext - shifted) : st_rem[j];
         q_in    = st_q[j];
         q_in[B] = take;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else begin
            v_ff <= st_v[j];
         end
         rem_ff <= rem_in;
         den_ff <= st_den[j];
         q_ff   <= q_in;
      end

      assign st_v[j+1]   = v_ff;
      assign st_rem[j+1] = rem_ff;
      assign st_den[j+1] = den_ff;
      assign st_q[j+1]   = q_ff;
   end

   assign out_valid = st_v[QW];
   assign out_quot  = st_q[QW];

endmodule

>>> hw/rtl/moller_expected_energy_unit.sv
// Top level of the Moller expected energy unit: beam register, cos^2, energy, divider.
// Depends on mee_pkg, mee_cos2, mee_energy, mee_div and the assertion header.
//
//   channel | ports                            | handshake
//   --------+----------------------------------+--------------------------
//   request | start, busy, req_theta_rad       | start high, busy low
//   result  | rsp_valid, rsp_expected_energy_ev| one-cycle strobe, no stall
//   csr     | csr_valid, csr_ready, csr_beam_* | valid and ready high
//
// One angle can enter every cycle; busy is never raised.
// The pipeline depth is the same at any parameter values: fold and squaring,
// nine Horner steps, final square, energy terms and a 35-stage restoring
// divider, one quotient bit per stage.
// Synchronous reset clears the valid bits and loads the beam register.
// The receiver cannot stall, so nothing inside ever holds.
`timescale 1ns / 1ps
`include "moller_expected_energy_unit_assert.svh"

module moller_expected_energy_unit #(
   parameter int ELECTRON_MASS_EV = 510999,
   parameter int ANGLE_FRAC_BITS  = 22,
   parameter int COSINE_FRAC_BITS = 30
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [mee_pkg::ANGLE_WIDTH-1:0]    req_theta_rad,
   output logic                               rsp_valid,
   output logic [mee_pkg::ENERGY_WIDTH-1:0]   rsp_expected_energy_ev,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mee_pkg::ENERGY_WIDTH-1:0]   csr_beam_energy_ev
);

   localparam int F       = COSINE_FRAC_BITS;
   localparam int EW      = mee_pkg::ENERGY_WIDTH;
   localparam int MW      = $clog2(ELECTRON_MASS_EV + 1);
   localparam int NW      = EW + 2 + F;
   localparam int TOPW    = NW + MW + 2;
   localparam int DW      = NW + 1;
   localparam int LATENCY = mee_pkg::PIPE_LATENCY;

   logic [EW-1:0]   beam_ff, beam_in;
   logic            c2_valid, en_valid;
   logic [F:0]      c2;
   logic [TOPW-1:0] top;
   logic [DW-1:0]   den2;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_comb begin
      beam_in = beam_ff;
      if (csr_valid && csr_ready) begin
         beam_in = csr_beam_energy_ev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beam_ff <= mee_pkg::BEAM_RESET;
      end else begin
         beam_ff <= beam_in;
      end
   end

   mee_cos2 #(
      .ANGLE_FRAC_BITS  (ANGLE_FRAC_BITS),
      .COSINE_FRAC_BITS (COSINE_FRAC_BITS)
   ) u_cos2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_theta  (req_theta_rad),
      .out_valid (c2_valid),
      .out_c2    (c2)
   );

   mee_energy #(
      .ELECTRON_MASS_EV (ELECTRON_MASS_EV),
      .F                (F),
      .TOPW             (TOPW),
      .DW               (DW)
   ) u_energy (
      .clock     (clock),
      .reset     (reset),
      .beam      (beam_ff),
      .in_valid  (c2_valid),
      .in_c2     (c2),
      .out_valid (en_valid),
      .out_top   (top),
      .out_den2  (den2)
   );

   mee_div #(
      .TOPW (TOPW),
      .DW   (DW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (en_valid),
      .in_top    (top),
      .in_den2   (den2),
      .out_valid (rsp_valid),
      .out_quot  (rsp_expected_energy_ev)
   );

   // every accepted transaction produces a result, and no result appears without one
   `MEE_ASSERT_IMPLY(a_req_to_rsp, clock, reset, start && !busy, ##LATENCY rsp_valid, "result missing")
   `MEE_ASSERT_IMPLY(a_rsp_from_req, clock, reset, rsp_valid, $past(start, LATENCY), "result without request")

endmodule

>>> verif/tb_top.sv
// Self-checking bench for moller_expected_energy_unit: angle transactions with a bit-exact
// energy predictor, beam register writes between phases. Depends on mee_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;

   localparam int          MASS_EV     = 510999;
   localparam int          COS_FRAC    = 30;
   localparam int          ANG_FRAC    = 22;
   localparam int          SETTLE_CYC  = 90;
   localparam int          WDOG_LIMIT  = 5000;
   localparam logic [23:0] THETA_PI    = 24'd13176795;

   typedef enum logic [1:0] {OP_ANGLE, OP_BEAM, OP_DRAIN} op_type;
   typedef struct packed {
      op_type                           op;
      logic                             calm;
      logic [mee_pkg::ENERGY_WIDTH-1:0] value;
   } job_type;

   logic                             clock;
   logic                             reset;
   logic                             start;
   logic                             busy;
   logic [mee_pkg::ANGLE_WIDTH-1:0]  req_theta_rad;
   logic                             rsp_valid;
   logic [mee_pkg::ENERGY_WIDTH-1:0] rsp_expected_energy_ev;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [mee_pkg::ENERGY_WIDTH-1:0] csr_beam_energy_ev;

   job_type                          job_q[$];
   logic [mee_pkg::ENERGY_WIDTH-1:0] energy_q[$];
   logic [mee_pkg::ENERGY_WIDTH-1:0] beam_now;
   logic                             req_taken, csr_taken;
   int                               gap_cnt, settle_cnt, idle_cnt;
   bit                               failed;

   moller_expected_energy_unit u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_theta_rad(req_theta_rad), .rsp_valid(rsp_valid),
      .rsp_expected_energy_ev(rsp_expected_energy_ev), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_beam_energy_ev(csr_beam_energy_ev)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Expected scattered energy for one angle at the given beam energy
   function automatic logic [mee_pkg::ENERGY_WIDTH-1:0] moller_energy_of(
         input logic [mee_pkg::ANGLE_WIDTH-1:0] theta,
         input logic [mee_pkg::ENERGY_WIDTH-1:0] beam);
      logic [127:0] one, pi_f, half_f, x, x2, t, p, c2, e, m, d;
      logic [127:0] base_n, base_d, term_n, term_d, num, den, quo;
      one    = 128'd1 << COS_FRAC;
      pi_f   = {64'd0, mee_pkg::PI_Q62} >> (62 - COS_FRAC);
      half_f = pi_f >> 1;
      x      = {104'd0, theta} << (COS_FRAC - ANG_FRAC);
      if (x > half_f)
         x = (x > pi_f) ? x - pi_f : pi_f - x;
      x2 = (x * x) >> COS_FRAC;
      t  = one;
      for (int k = 9; k >= 1; k--) begin
         p = ((t * x2) >> COS_FRAC) / (2 * k * (2 * k - 1));
         t = (p >= one) ? 128'd0 : one - p;
      end
      c2     = (t * t) >> COS_FRAC;
      e      = beam;
      m      = MASS_EV;
      d      = (e >= m) ? e - m : m - e;
      base_n = (m * (e + m)) << COS_FRAC;
      base_d = (e + m) << COS_FRAC;
      term_n = m * d * c2;
      term_d = d * c2;
      if (e >= m) begin
         num = base_n + term_n;
         den = base_d - term_d;
      end else begin
         num = base_n - term_n;
         den = base_d + term_d;
      end
      quo = ((num << 1) + den) / (den << 1);
      return quo[mee_pkg::ENERGY_WIDTH-1:0];
   endfunction

   // driver: one nonblocking update per signal per falling edge
   always @(negedge clock) begin
      logic                             s_n, c_n;
      logic [mee_pkg::ANGLE_WIDTH-1:0]  th_n;
      logic [mee_pkg::ENERGY_WIDTH-1:0] bd_n;
      job_type                          j;
      s_n  = start;
      c_n  = csr_valid;
      th_n = req_theta_rad;
      bd_n = csr_beam_energy_ev;
      if (!reset && !(start && !req_taken) && !(csr_valid && !csr_taken)) begin
         s_n = 1'b0;
         c_n = 1'b0;
         if (gap_cnt > 0) begin
            gap_cnt = gap_cnt - 1;
         end else if (job_q.size() > 0) begin
            j = job_q[0];
            if (j.op == OP_ANGLE) begin
               if (!j.calm && $urandom_range(0, 11) == 0) begin
                  gap_cnt = $urandom_range(1, 17) - 1;
               end else begin
                  void'(job_q.pop_front());
                  s_n  = 1'b1;
                  th_n = j.value[mee_pkg::ANGLE_WIDTH-1:0];
               end
            end else if (energy_q.size() > 0) begin
               settle_cnt = 0;
            end else if (settle_cnt < SETTLE_CYC) begin
               settle_cnt = settle_cnt + 1;
            end else begin
               void'(job_q.pop_front());
               settle_cnt = 0;
               if (j.op == OP_BEAM) begin
                  c_n  = 1'b1;
                  bd_n = j.value;
               end
            end
         end
      end
      start              <= s_n;
      csr_valid          <= c_n;
      req_theta_rad      <= th_n;
      csr_beam_energy_ev <= bd_n;
   end

   // monitor and predictor update
   always @(posedge clock) begin
      logic [mee_pkg::ENERGY_WIDTH-1:0] want;
      req_taken <= start && !busy && !reset;
      csr_taken <= csr_valid && csr_ready && !reset;
      if (reset) begin
         beam_now <= mee_pkg::BEAM_RESET;
      end else begin
         if (csr_valid && csr_ready)
            beam_now <= csr_beam_energy_ev;
         if (start && !busy)
            energy_q.push_back(moller_energy_of(req_theta_rad, beam_now));
         if (rsp_valid) begin
            if (energy_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %0d",
                        $time, rsp_expected_energy_ev);
               failed = 1'b1;
            end else begin
               want = energy_q.pop_front();
               if (want !== rsp_expected_energy_ev) begin
                  $display("%0t: expected_energy_ev mismatch, expected %0d, actual %0d",
                           $time, want, rsp_expected_energy_ev);
                  failed = 1'b1;
               end
            end
         end
      end
   end

   // watchdog on cycles with no transaction on any channel
   always @(posedge clock) begin
      if (reset || (start && !busy) || (csr_valid && csr_ready) || rsp_valid)
         idle_cnt <= 0;
      else if (idle_cnt >= WDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else
         idle_cnt <= idle_cnt + 1;
   end

   function automatic job_type mk(input op_type op,
                                  input logic [mee_pkg::ENERGY_WIDTH-1:0] v,
                                  input logic calm);
      job_type j;
      j.op    = op;
      j.calm  = calm;
      j.value = v;
      return j;
   endfunction

   function automatic logic [23:0] rand_theta();
      if ($urandom_range(0, 7) == 0)
         return 24'($urandom);
      return 24'($urandom_range(0, THETA_PI));
   endfunction

   initial begin
      logic [mee_pkg::ENERGY_WIDTH-1:0] beams[7];
      logic [63:0]                      r;
      reset      = 1'b1;
      start      = 1'b0;
      csr_valid  = 1'b0;
      req_theta_rad      = '0;
      csr_beam_energy_ev = '0;
      req_taken  = 1'b0;
      csr_taken  = 1'b0;
      gap_cnt    = 0;
      settle_cnt = 0;
      idle_cnt   = 0;
      failed     = 1'b0;

      // directed angles at reset beam: extremes, pi, pi/2, bit patterns
      foreach (beams[i]) beams[i] = '0;
      job_q.push_back(mk(OP_ANGLE, 0, 1'b1));
      job_q.push_back(mk(OP_ANGLE, 1, 1'b1));
      job_q.push_back(mk(OP_ANGLE, 24'hFFFFFF, 1'b1));
      job_q.push_back(mk(OP_ANGLE, THETA_PI, 1'b1));
      job_q.push_back(mk(OP_ANGLE, THETA_PI + 1, 1'b1));
      job_q.push_back(mk(OP_ANGLE, THETA_PI >> 1, 1'b1));
      job_q.push_back(mk(OP_ANGLE, (THETA_PI >> 1) + 1, 1'b1));
      job_q.push_back(mk(OP_ANGLE, 24'hAAAAAA, 1'b1));
      job_q.push_back(mk(OP_ANGLE, 24'h555555, 1'b1));
      job_q.push_back(mk(OP_ANGLE, 24'h800000, 1'b1));
      // beam at zero and at 20000000000, the top of the random beam range
      job_q.push_back(mk(OP_BEAM, 0, 1'b1));
      job_q.push_back(mk(OP_ANGLE, 0, 1'b1));
      job_q.push_back(mk(OP_ANGLE, THETA_PI >> 1, 1'b1));
      job_q.push_back(mk(OP_ANGLE, 24'hFFFFFF, 1'b1));
      job_q.push_back(mk(OP_BEAM, 35'd20000000000, 1'b1));
      job_q.push_back(mk(OP_ANGLE, 0, 1'b1));
      job_q.push_back(mk(OP_ANGLE, THETA_PI, 1'b1));
      job_q.push_back(mk(OP_ANGLE, THETA_PI >> 1, 1'b1));
      job_q.push_back(mk(OP_ANGLE, 24'hFFFFFF, 1'b1));

      // random phases: equal to mass, just below it, full 35 bits, one, reset value, random
      beams[0] = MASS_EV;
      beams[1] = MASS_EV - 1;
      beams[2] = '1;
      beams[3] = 35'd1;
      beams[4] = mee_pkg::BEAM_RESET;
      for (int b = 0; b < 7; b++) begin
         if (b >= 5) begin
            r = {$urandom, $urandom};
            beams[b] = 35'(r % 64'd20000000001);
         end
         job_q.push_back(mk(OP_BEAM, beams[b], 1'b0));
         for (int n = 0; n < 140; n++) begin
            if (n == 70 && b == 2)
               job_q.push_back(mk(OP_DRAIN, 0, 1'b0));
            job_q.push_back(mk(OP_ANGLE, rand_theta(), b == 6));
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (job_q.size() > 0 || start || csr_valid || energy_q.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
      if (!failed && energy_q.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
